// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check an implication that holds in the same cycle
`define ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// File: sv/mm3h_pkg.sv
package mm3h_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned CountWidth = 3;

   localparam logic [WordWidth-1:0] MulC1 = 32'hcc9e2d51;
   localparam logic [WordWidth-1:0] MulC2 = 32'h1b873593;
   localparam logic [WordWidth-1:0] AddN = 32'he6546b64;
   localparam logic [WordWidth-1:0] FinM1 = 32'h85ebca6b;
   localparam logic [WordWidth-1:0] FinM2 = 32'hc2b2ae35;
   localparam logic [WordWidth-1:0] SeedReset = 32'd37;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MIX,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul1;
      logic mul2;
      logic mix;
      logic fin1;
      logic fin2;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic final_item;
   } dp_sts_type;

   function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] v,
                                                 input int unsigned s);
      rotl = (v << s) | (v >> (WordWidth - s));
   endfunction

endpackage

// File: sv/mm3h_ctrl.sv
`include "assert_macros.svh"

module mm3h_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  mm3h_pkg::dp_sts_type sts,
   output mm3h_pkg::dp_cmd_type cmd
);
   import mm3h_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            state_in = sts.final_item ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_CLK(a_accept_starts, req_tvalid && req_tready |=> state_ff == ST_MUL1, "beat not taken")
   `ASSERT_IMP(a_no_overwrite, cmd.out_load, (!rsp_valid_ff || rsp_tready), "result overwritten")
   `ASSERT_IMP(a_busy_blocks, state_ff != ST_IDLE, !req_tready, "beat accepted while busy")
   `ASSERT_CLK(a_load_shows, cmd.out_load |=> rsp_tvalid, "loaded result not presented")

endmodule

// File: sv/mm3h_datapath.sv
module mm3h_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mm3h_pkg::WordWidth-1:0]       csr_wdata,
   input  logic [mm3h_pkg::WordWidth-1:0]       key_word,
   input  logic [mm3h_pkg::CountWidth-1:0]      byte_count,
   input  logic                                 last_word,
   input  mm3h_pkg::dp_cmd_type                 cmd,
   output mm3h_pkg::dp_sts_type                 sts,
   output logic [mm3h_pkg::WordWidth-1:0]       hash_value,
   output logic [mm3h_pkg::WordWidth-1:0]       key_length
);
   import mm3h_pkg::*;

   logic [WordWidth-1:0] seed_ff;
   logic [WordWidth-1:0] k_ff;
   logic [WordWidth-1:0] hash_ff;
   logic [WordWidth-1:0] len_ff;
   logic                 full_ff;
   logic                 final_ff;
   logic                 in_key_ff;
   logic [WordWidth-1:0] rsp_hash_ff;
   logic [WordWidth-1:0] rsp_len_ff;

   logic [WordWidth-1:0] word_mask;
   logic [WordWidth-1:0] count_ext;
   logic [WordWidth-1:0] mul_a;
   logic [WordWidth-1:0] mul_b;
   logic [WordWidth-1:0] prod;
   logic [WordWidth-1:0] mix_x;
   logic [WordWidth-1:0] mix_r;
   logic [WordWidth-1:0] fin_x;

   always_comb begin
      case (byte_count)
         3'd0:    word_mask = 32'h0000_0000;
         3'd1:    word_mask = 32'h0000_00ff;
         3'd2:    word_mask = 32'h0000_ffff;
         3'd3:    word_mask = 32'h00ff_ffff;
         default: word_mask = 32'hffff_ffff;
      endcase
   end

   assign count_ext = byte_count[2] ? WordWidth'(4)
                                    : {{(WordWidth-CountWidth){1'b0}}, byte_count};

   assign fin_x = hash_ff ^ len_ff;
   assign mix_x = hash_ff ^ k_ff;
   assign mix_r = rotl(mix_x, 13);

   always_comb begin
      mul_a = k_ff;
      mul_b = MulC1;
      if (cmd.mul2) begin
         mul_a = rotl(k_ff, 15);
         mul_b = MulC2;
      end else if (cmd.fin1) begin
         mul_a = fin_x ^ (fin_x >> 16);
         mul_b = FinM1;
      end else if (cmd.fin2) begin
         mul_a = hash_ff ^ (hash_ff >> 13);
         mul_b = FinM2;
      end
   end

   assign prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
         in_key_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            seed_ff <= csr_wdata;
         end
         if (cmd.mix) begin
            in_key_ff <= !final_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         k_ff <= key_word & word_mask;
         hash_ff <= in_key_ff ? hash_ff : seed_ff;
         len_ff <= (in_key_ff ? len_ff : '0) + count_ext;
         full_ff <= byte_count[2];
         final_ff <= last_word || !byte_count[2];
      end
      if (cmd.mul1 || cmd.mul2) begin
         k_ff <= prod;
      end
      if (cmd.mix) begin
         hash_ff <= full_ff ? ((mix_r << 2) + mix_r + AddN) : mix_x;
      end
      if (cmd.fin1 || cmd.fin2) begin
         hash_ff <= prod;
      end
      if (cmd.out_load) begin
         rsp_hash_ff <= hash_ff ^ (hash_ff >> 16);
         rsp_len_ff <= len_ff;
      end
   end

   assign sts.final_item = final_ff;
   assign hash_value = rsp_hash_ff;
   assign key_length = rsp_len_ff;

endmodule

// File: sv/murmur3_32bit_hash_unit.sv
// MurmurHash3 x86_32 engine for keys streamed as little-endian 32-bit words.
// Slave channel req_*: one beat carries key_word and byte_count in tdata and
// last_word in tlast. Every beat before the last holds 4 bytes; a beat with
// fewer than 4 bytes ends the key even without tlast. Bytes above byte_count
// are ignored, and counts above 4 count as 4.
// Master channel rsp_*: one beat per key, hash in tdata[31:0], the key length
// modulo 2^32 in tdata[63:32].
// csr_we/csr_wdata write the seed; a new seed applies from the next key.
// Datapath: one shared 32x32 multiplier does the c1, c2 and fmix products, so
// a beat that does not end a key steps through accept, two multiplies and mix. A
// final beat then goes on through fin1, fin2 and fin3, where its result is
// registered on rsp_*, after which req_tready rises again.
// The result sits in an output register: the next key streams in while it
// waits. If a second result is ready before the first is taken, the engine
// holds it and stalls req_tready until rsp_tready frees the register.
// Reset (synchronous) sets the seed to 37, drops any partial key and clears
// rsp_tvalid.
module murmur3_32bit_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // key_word[31:0], byte_count[34:32], zero pad
   input  logic        req_tlast,  // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // hash_value[31:0], key_length[63:32]
);
   import mm3h_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [WordWidth-1:0] hash_value;
   logic [WordWidth-1:0] key_length;

   mm3h_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mm3h_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .key_word   (req_tdata[31:0]),
      .byte_count (req_tdata[34:32]),
      .last_word  (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .hash_value (hash_value),
      .key_length (key_length)
   );

   assign rsp_tdata = {key_length, hash_value};

endmodule
